/* src/simplex_measure_assert.svh */
// Assertion macros for the simplex measure block.
// Included by the top level only; no other dependencies.
`ifndef SIMPLEX_MEASURE_ASSERT_SVH
`define SIMPLEX_MEASURE_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define SMEAS_ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("simplex_measure: implication check failed");

// Condition that must never be seen outside reset
`define SMEAS_ASSERT_NEVER(lbl, ck, rs, cond) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(cond)) \
    else $error("simplex_measure: forbidden condition seen");

`endif

/* src/smeas_pkg.sv */
// Shared types and constants for the simplex measure block.
// No dependencies; imported by every module of the block.
`default_nettype none

package smeas_pkg;

  localparam int COORD_W  = 16;
  localparam int NUM_COORD = 12;
  localparam int EDGE_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * EDGE_W;
  localparam int MEAS_W   = 56;
  localparam int ROOT_W   = 43;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int REM_W    = ROOT_W + 3;
  localparam int DIM_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int IN_DATA_W = COORD_W * NUM_COORD;
  localparam int OUT_DATA_W = 56;

  // 1.0 with 24 fraction bits
  localparam logic [MEAS_W-1:0] ONE_Q24 = MEAS_W'(1) << 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WORLD_DIM = 1'b0,
    CFG_ELEM_DIM  = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    MODE_ONE   = 3'd0,
    MODE_ERR   = 3'd1,
    MODE_W1    = 3'd2,
    MODE_LEN2  = 3'd3,
    MODE_DET2  = 3'd4,
    MODE_LEN3  = 3'd5,
    MODE_AREA3 = 3'd6,
    MODE_VOL3  = 3'd7
  } mode_t;

  typedef struct packed {
    mode_t                               mode;
    logic [NUM_COORD-1:0][COORD_W-1:0]  coord;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic              use_root;
    logic              err;
    logic [MEAS_W-1:0] direct;
  } side_t;

endpackage

`default_nettype wire

/* src/smeas_front.sv */
// Front end: configuration registers and item classification.
// Depends on smeas_pkg.
`default_nettype none

module smeas_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [smeas_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [smeas_pkg::DIM_W-1:0]     cfg_data,
  input  wire logic [smeas_pkg::IN_DATA_W-1:0] in_data,
  output smeas_pkg::item_t                     item
);
  import smeas_pkg::*;

  logic [DIM_W-1:0] world_dim;
  logic [DIM_W-1:0] elem_dim;
  mode_t            mode;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      world_dim <= DIM_W'(3);
      elem_dim  <= DIM_W'(3);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_WORLD_DIM: world_dim <= cfg_data;
        CFG_ELEM_DIM:  elem_dim  <= cfg_data;
        default: ;
      endcase
    end
  end

  // classify the transaction by the dimensions
  always_comb begin
    priority if (elem_dim == '0)        mode = MODE_ONE;
    else if (elem_dim > world_dim)      mode = MODE_ERR;
    else if (world_dim == DIM_W'(1))    mode = MODE_W1;
    else if (world_dim == DIM_W'(2))    mode = (elem_dim == DIM_W'(1)) ? MODE_LEN2 : MODE_DET2;
    else if (elem_dim == DIM_W'(1))     mode = MODE_LEN3;
    else if (elem_dim == DIM_W'(2))     mode = MODE_AREA3;
    else                                mode = MODE_VOL3;
  end

  assign item.mode  = mode;
  assign item.coord = in_data;

endmodule

`default_nettype wire

/* src/smeas_queue.sv */
// Two-entry queue between classifier and arithmetic pipeline.
// Depends on smeas_pkg.
`default_nettype none

module smeas_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  smeas_pkg::item_t   push_item,
  input  wire logic          pop,
  output smeas_pkg::item_t   head,
  output smeas_pkg::q_status_t status
);
  import smeas_pkg::*;

  item_t      mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] cnt;

  // storage
  always_ff @(posedge clk) begin
    if (push && !status.full) mem[wptr] <= push_item;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push && !status.full) wptr <= ~wptr;
      if (pop && !status.empty) rptr <= ~rptr;
      cnt <= cnt + 2'((push && !status.full)) - 2'((pop && !status.empty));
    end
  end

  assign head         = mem[rptr];
  assign status.full  = (cnt == 2'd2);
  assign status.empty = (cnt == 2'd0);

endmodule

`default_nettype wire

/* src/smeas_sqrt.sv */
// Pipelined integer square root, one result bit per stage, with sideband.
// Depends on smeas_pkg.
`default_nettype none

module smeas_sqrt (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic                         in_valid,
  input  wire logic [smeas_pkg::RAD_W-1:0]  in_rad,
  input  smeas_pkg::side_t                  in_side,
  output logic                              out_valid,
  output logic [smeas_pkg::ROOT_W-1:0]      out_root,
  output smeas_pkg::side_t                  out_side
);
  import smeas_pkg::*;

  logic [RAD_W-1:0]  rad_q  [ROOT_W+1];
  logic [REM_W-1:0]  rem_q  [ROOT_W+1];
  logic [ROOT_W-1:0] root_q [ROOT_W+1];
  side_t             side_q [ROOT_W+1];
  logic              vld_q  [ROOT_W+1];

  assign rad_q[0]  = in_rad;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign side_q[0] = in_side;
  assign vld_q[0]  = in_valid;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             fits;

    // bring down the next bit pair and try the next root bit
    always_comb begin
      rem_sh = {rem_q[k][REM_W-3:0], rad_q[k][RAD_W-1 -: 2]};
      trial  = {{(REM_W-ROOT_W-2){1'b0}}, root_q[k], 2'b01};
      fits   = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[k+1]  <= rad_q[k] << 2;
        rem_q[k+1]  <= fits ? (rem_sh - trial) : rem_sh;
        root_q[k+1] <= {root_q[k][ROOT_W-2:0], fits};
        side_q[k+1] <= side_q[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rst)     vld_q[k+1] <= 1'b0;
      else if (en) vld_q[k+1] <= vld_q[k];
    end
  end

  assign out_valid = vld_q[ROOT_W];
  assign out_root  = root_q[ROOT_W];
  assign out_side  = side_q[ROOT_W];

endmodule

`default_nettype wire

/* src/smeas_back.sv */
// Arithmetic pipeline: edges, products, cross product, sums, root.
// Depends on smeas_pkg and smeas_sqrt.
`default_nettype none

module smeas_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  smeas_pkg::item_t                  in_item,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [smeas_pkg::MEAS_W-1:0]      out_measure,
  output logic                              out_err
);
  import smeas_pkg::*;

  logic en;

  // stage 1: edge vectors
  logic                     v1;
  mode_t                    m1;
  logic signed [EDGE_W-1:0] e1 [3];
  logic signed [EDGE_W-1:0] e2 [3];
  logic signed [EDGE_W-1:0] e3 [3];

  // stage 2: products and edge squares
  logic                     v2;
  mode_t                    m2;
  logic signed [PROD_W-1:0] p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;
  logic [31:0]              sq1 [3];
  logic signed [EDGE_W-1:0] e3_2 [3];
  logic [15:0]              ax_2;

  // stage 3: cross product and edge norm sum
  logic                     v3;
  mode_t                    m3;
  logic signed [PROD_W-1:0] n [3];
  logic [33:0]              ssum1_3;
  logic signed [EDGE_W-1:0] e3_3 [3];
  logic [15:0]              ax_3;

  // stage 4: triple terms and normal squares
  logic                     v4;
  mode_t                    m4;
  logic signed [50:0]       t [3];
  logic [65:0]              nsq [3];
  logic [33:0]              ssum1_4;
  logic [32:0]              adet_4;
  logic [15:0]              ax_4;

  // stage 5: selection
  logic                     v5;
  logic [RAD_W-1:0]         rad5;
  side_t                    side5;

  logic signed [52:0]       tsum;
  logic [67:0]              nsum;
  logic [RAD_W-1:0]         rad_sel;
  side_t                    side_sel;

  logic [ROOT_W-1:0]        root;
  side_t                    side_out;

  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (en) begin
      m1 <= in_item.mode;
      for (int c = 0; c < 3; c++) begin
        e1[c] <= EDGE_W'($signed(in_item.coord[3+c])) - EDGE_W'($signed(in_item.coord[c]));
        e2[c] <= EDGE_W'($signed(in_item.coord[6+c])) - EDGE_W'($signed(in_item.coord[c]));
        e3[c] <= EDGE_W'($signed(in_item.coord[9+c])) - EDGE_W'($signed(in_item.coord[c]));
      end
    end
  end

  // stage 2
  always_ff @(posedge clk) begin
    logic [15:0] a;
    if (en) begin
      m2   <= m1;
      p_yz <= e1[1] * e2[2];
      p_zy <= e1[2] * e2[1];
      p_zx <= e1[2] * e2[0];
      p_xz <= e1[0] * e2[2];
      p_xy <= e1[0] * e2[1];
      p_yx <= e1[1] * e2[0];
      for (int c = 0; c < 3; c++) begin
        a = e1[c][EDGE_W-1] ? 16'(-e1[c]) : 16'(e1[c]);
        // a 2D world ignores the z coordinate
        sq1[c]  <= (c == 2 && m1 == MODE_LEN2) ? 32'd0 : a * a;
        e3_2[c] <= e3[c];
      end
      ax_2 <= e1[0][EDGE_W-1] ? 16'(-e1[0]) : 16'(e1[0]);
    end
  end

  // stage 3
  always_ff @(posedge clk) begin
    if (en) begin
      m3      <= m2;
      n[0]    <= p_yz - p_zy;
      n[1]    <= p_zx - p_xz;
      n[2]    <= p_xy - p_yx;
      ssum1_3 <= 34'(sq1[0]) + 34'(sq1[1]) + 34'(sq1[2]);
      e3_3    <= e3_2;
      ax_3    <= ax_2;
    end
  end

  // stage 4
  always_ff @(posedge clk) begin
    logic [32:0] an;
    if (en) begin
      m4 <= m3;
      for (int c = 0; c < 3; c++) begin
        an     = n[c][PROD_W-1] ? 33'(-n[c]) : 33'(n[c]);
        t[c]   <= n[c] * e3_3[c];
        nsq[c] <= an * an;
      end
      adet_4  <= n[2][PROD_W-1] ? 33'(-n[2]) : 33'(n[2]);
      ssum1_4 <= ssum1_3;
      ax_4    <= ax_3;
    end
  end

  // stage 5: pick the direct result or the radicand, or flag a dimension error
  always_comb begin
    tsum = 53'(t[0]) + 53'(t[1]) + 53'(t[2]);
    nsum = 68'(nsq[0]) + 68'(nsq[1]) + 68'(nsq[2]);
    rad_sel = '0;
    side_sel.use_root = 1'b0;
    side_sel.err      = 1'b0;
    side_sel.direct   = '0;
    unique case (m4)
      MODE_ONE:  side_sel.direct = ONE_Q24;
      MODE_ERR:  side_sel.err    = 1'b1;
      MODE_W1:   side_sel.direct = MEAS_W'(ax_4) << 16;
      MODE_DET2: side_sel.direct = MEAS_W'(adet_4) << 8;
      MODE_VOL3: side_sel.direct = tsum[52] ? MEAS_W'(-tsum) : MEAS_W'(tsum);
      MODE_LEN2, MODE_LEN3: begin
        side_sel.use_root = 1'b1;
        rad_sel = RAD_W'(ssum1_4) << 32;
      end
      MODE_AREA3: begin
        side_sel.use_root = 1'b1;
        rad_sel = RAD_W'(nsum) << 16;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad5  <= rad_sel;
      side5 <= side_sel;
    end
  end

  smeas_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v5),
    .in_rad    (rad5),
    .in_side   (side5),
    .out_valid (out_valid),
    .out_root  (root),
    .out_side  (side_out)
  );

  // the last root stage is the output register; the whole line holds on a stall
  assign en          = !out_valid || out_ready;
  assign out_measure = side_out.use_root ? MEAS_W'(root) : side_out.direct;
  assign out_err     = side_out.err;

endmodule

`default_nettype wire

/* src/simplex_measure.sv */
// Channel  | Ports                     | Contents
// input    | s_axis_tvalid/tready/tdata | 12 signed Q8.8 coordinates
// output   | m_axis_tvalid/tready/tdata/tuser | measure Q.24, dimension error
// config   | cfg_we/cfg_idx/cfg_data   | world_dim, elem_dim
// One transaction per cycle. Each accepted input transaction is loaded into the queue register
// at the accepting edge, then passes through 5 arithmetic stages and 43 bit-per-stage root
// stages, the last of which holds the result. Reset is synchronous and clears the queue and all
// stage valid bits. An output stall holds the whole pipeline and adds its length to
// the latency; the two-entry queue keeps taking input until it fills.
// Top level; depends on smeas_pkg, smeas_front, smeas_queue, smeas_back.
`default_nettype none

module simplex_measure (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // v0_x, v0_y, v0_z, v1_x, ... v3_z, 16 bits each, from bit 0 up
  input  wire logic [smeas_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // measure in bits 55:0
  output logic [smeas_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // dim_error
  output logic                                  m_axis_tuser,
  input  wire logic                             cfg_we,
  input  wire logic [smeas_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [smeas_pkg::DIM_W-1:0]      cfg_data
);
  import smeas_pkg::*;

  `include "simplex_measure_assert.svh"

  item_t     f_item;
  item_t     q_head;
  q_status_t q_stat;
  logic      b_ready;
  logic [MEAS_W-1:0] measure;

  smeas_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_data  (s_axis_tdata),
    .item     (f_item)
  );

  smeas_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_axis_tvalid),
    .push_item (f_item),
    .pop       (b_ready),
    .head      (q_head),
    .status    (q_stat)
  );

  smeas_back u_back (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (!q_stat.empty),
    .in_ready    (b_ready),
    .in_item     (q_head),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_measure (measure),
    .out_err     (m_axis_tuser)
  );

  assign s_axis_tready = !q_stat.full;
  assign m_axis_tdata  = measure;

  // checks
  `SMEAS_ASSERT_IMPL(a_err_zero, clk, rst, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)
  `SMEAS_ASSERT_NEVER(a_q_status, clk, rst, q_stat.full && q_stat.empty)
  `SMEAS_ASSERT_IMPL(a_stall_full, clk, rst, !s_axis_tready, q_stat.full)

endmodule

`default_nettype wire

/* test/simplex_measure_tb.sv */
// Self-checking testbench for simplex_measure: walks through world and element
// dimension settings, streams simplices and compares every result with its own model.
// Depends on smeas_pkg and the simplex_measure RTL only.
`default_nettype none

module simplex_measure_tb;
  import smeas_pkg::*;

  typedef struct {
    logic [MEAS_W-1:0] measure;
    logic              dim_error;
  } measure_res_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_we = 1'b0;
  cfg_idx_t              cfg_idx = CFG_WORLD_DIM;
  logic [DIM_W-1:0]      cfg_data = '0;

  simplex_measure i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  // model copy of the registers, reset values
  logic [DIM_W-1:0] world_dim = 2'd3;
  logic [DIM_W-1:0] elem_dim  = 2'd3;

  logic [IN_DATA_W-1:0] simplex_q[$];
  measure_res_t         measure_q[$];
  int unsigned          errors = 0;
  int unsigned          n_sent = 0;
  int unsigned          n_seen = 0;
  int unsigned          cycles = 0;
  bit                   quiet = 1'b0;
  bit                   hold_req = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAIL simplex_measure");
      $finish;
    end
  end

  // floor square root of a 128-bit radicand, bit per step
  function automatic logic [63:0] isqrt(logic [127:0] x);
    logic [129:0] rem;
    logic [129:0] trial;
    logic [63:0]  root;
    rem  = '0;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      rem   = (rem << 2) | 130'(x[2*i +: 2]);
      trial = (130'(root) << 2) | 130'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic logic [127:0] sq_mag(longint v);
    logic [127:0] m;
    m = 128'(v < 0 ? -v : v);
    return m * m;
  endfunction

  // measure of one simplex under the current dimensions
  function automatic measure_res_t simplex_measure_of(logic [IN_DATA_W-1:0] d);
    measure_res_t r;
    longint c[12];
    longint e1[3], e2[3], e3[3], nrm[3];
    longint t;
    for (int i = 0; i < 12; i++) c[i] = longint'($signed(d[16*i +: 16]));
    for (int i = 0; i < 3; i++) begin
      e1[i] = c[3+i] - c[i];
      e2[i] = c[6+i] - c[i];
      e3[i] = c[9+i] - c[i];
    end
    nrm[0] = e1[1]*e2[2] - e1[2]*e2[1];
    nrm[1] = e1[2]*e2[0] - e1[0]*e2[2];
    nrm[2] = e1[0]*e2[1] - e1[1]*e2[0];
    r.measure   = '0;
    r.dim_error = 1'b0;
    if (elem_dim == 0) begin
      r.measure = ONE_Q24;
    end else if (elem_dim > world_dim) begin
      r.dim_error = 1'b1;
    end else if (world_dim == 1) begin
      r.measure = MEAS_W'(e1[0] < 0 ? -e1[0] : e1[0]) << 16;
    end else if (world_dim == 2) begin
      if (elem_dim == 1) begin
        r.measure = MEAS_W'(isqrt((sq_mag(e1[0]) + sq_mag(e1[1])) << 32));
      end else begin
        r.measure = MEAS_W'(nrm[2] < 0 ? -nrm[2] : nrm[2]) << 8;
      end
    end else if (elem_dim == 1) begin
      r.measure = MEAS_W'(isqrt((sq_mag(e1[0]) + sq_mag(e1[1]) + sq_mag(e1[2])) << 32));
    end else if (elem_dim == 2) begin
      r.measure = MEAS_W'(isqrt((sq_mag(nrm[0]) + sq_mag(nrm[1]) + sq_mag(nrm[2])) << 16));
    end else begin
      t = nrm[0]*e3[0] + nrm[1]*e3[1] + nrm[2]*e3[2];
      r.measure = MEAS_W'(t < 0 ? -t : t);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    $display("mismatch %s: expected %0h got %0h (result %0d)", what, want, got, n_seen);
    errors++;
  endtask

  // append one simplex to the pending list
  task automatic queue_simplex(logic [IN_DATA_W-1:0] d);
    simplex_q.insert(simplex_q.size(), d);
  endtask

  // driver: feeds queued simplices, with random gaps
  int gap_left = 0;
  always @(posedge clk) begin
    logic                 nv;
    logic [IN_DATA_W-1:0] nd;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        measure_q.insert(measure_q.size(), simplex_measure_of(s_axis_tdata));
        n_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        nv = 1'b0;
        nd = s_axis_tdata;
        if (gap_left > 0) begin
          gap_left--;
        end else if (simplex_q.size() > 0) begin
          nv = 1'b1;
          nd = simplex_q.pop_front();
          if (!quiet && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 5);
        end
        s_axis_tvalid <= nv;
        s_axis_tdata  <= nd;
      end
    end
  end

  // monitor: checks each result transaction, stalls at random and once for a long hold
  int  stall_left = 0;
  bit  hold_done = 1'b0;
  always @(posedge clk) begin
    measure_res_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_seen++;
        if (measure_q.size() == 0) begin
          report_mismatch("unexpected result", 64'd0, 64'(m_axis_tdata));
        end else begin
          want = measure_q.pop_front();
          if (m_axis_tdata[MEAS_W-1:0] !== want.measure)
            report_mismatch("measure", 64'(want.measure), 64'(m_axis_tdata));
          if (m_axis_tuser !== want.dim_error)
            report_mismatch("dim_error", 64'(want.dim_error), 64'(m_axis_tuser));
        end
      end
      if (hold_req && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (!quiet && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 5);
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [DIM_W-1:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    if (idx == CFG_WORLD_DIM) world_dim = val;
    else elem_dim = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (simplex_q.size() != 0 || s_axis_tvalid || measure_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 1023)) - 16'd512;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [IN_DATA_W-1:0] rand_simplex();
    logic [IN_DATA_W-1:0] d;
    for (int i = 0; i < 12; i++) d[16*i +: 16] = rand_coord();
    return d;
  endfunction

  function automatic logic [IN_DATA_W-1:0] splat(logic [15:0] p0, logic [15:0] rest);
    logic [IN_DATA_W-1:0] d;
    for (int i = 0; i < 12; i++) d[16*i +: 16] = (i < 3) ? p0 : rest;
    return d;
  endfunction

  // world/elem settings per phase, extremes and error cases included
  localparam int N_PHASE = 16;
  logic [DIM_W-1:0] ph_world[N_PHASE] = '{2'd3, 2'd3, 2'd3, 2'd3, 2'd2, 2'd2, 2'd2, 2'd1,
                                          2'd1, 2'd0, 2'd0, 2'd0, 2'd2, 2'd1, 2'd1, 2'd3};
  logic [DIM_W-1:0] ph_elem [N_PHASE] = '{2'd3, 2'd2, 2'd1, 2'd0, 2'd2, 2'd1, 2'd3, 2'd1,
                                          2'd2, 2'd0, 2'd1, 2'd3, 2'd0, 2'd0, 2'd3, 2'd3};

  initial begin
    logic [IN_DATA_W-1:0] d;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < N_PHASE; p++) begin
      wait_drained();
      write_reg(CFG_WORLD_DIM, ph_world[p]);
      write_reg(CFG_ELEM_DIM, ph_elem[p]);
      quiet = (p >= N_PHASE - 3);
      if (p == 0) begin
        // corner simplices: zeros, extremes, largest edges, unit and degenerate shapes
        queue_simplex('0);
        queue_simplex({12{16'h7FFF}});
        queue_simplex({12{16'h8000}});
        queue_simplex(splat(16'h8000, 16'h7FFF));
        queue_simplex(splat(16'h7FFF, 16'h8000));
        queue_simplex({12{16'hFFFF}});
        queue_simplex({12{16'h5555}});
        queue_simplex({12{16'hAAAA}});
        d = '0;
        d[16*3 +: 16] = 16'h0100;
        d[16*7 +: 16] = 16'h0100;
        d[16*11 +: 16] = 16'h0100;
        queue_simplex(d);
        d[16*11 +: 16] = 16'h0000;
        queue_simplex(d);
        d = '0;
        d[16*3 +: 16] = 16'h8000;
        d[16*4 +: 16] = 16'h8000;
        d[16*5 +: 16] = 16'h8000;
        d[16*6 +: 16] = 16'h7FFF;
        d[16*10 +: 16] = 16'h7FFF;
        queue_simplex(d);
      end
      if (p == 1) hold_req = 1'b1;
      for (int k = 0; k < 56; k++) queue_simplex(rand_simplex());
    end

    wait_drained();
    repeat (80) @(posedge clk);
    $display("covered %0d simplices over %0d dimension settings, %0d results checked",
             n_sent, N_PHASE, n_seen);
    if (errors == 0 && measure_q.size() == 0) begin
      $display("PASS simplex_measure");
    end else begin
      $display("FAIL simplex_measure");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
+incdir+src
src/smeas_pkg.sv
src/smeas_front.sv
src/smeas_queue.sv
src/smeas_sqrt.sv
src/smeas_back.sv
src/simplex_measure.sv
test/simplex_measure_tb.sv
